// File: rtl/sdwl_pkg.sv
// Types, codes and helper functions shared by the sorted dictionary word labeler.
package sdwl_pkg;

    localparam int WORD_W     = 256;
    localparam int PART_W     = 64;
    localparam int SCORE_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int LABEL_W    = 2;
    localparam int LOC_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [SCORE_W-1:0] SCORE_MAX       = 7'd100;
    localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 7'd80;

    localparam logic [STATUS_W-1:0] STATUS_LOOKUP  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    localparam logic [LABEL_W-1:0] LABEL_NONE  = 2'd0;
    localparam logic [LABEL_W-1:0] LABEL_FIRST = 2'd1;
    localparam logic [LABEL_W-1:0] LABEL_LAST  = 2'd2;
    localparam logic [LABEL_W-1:0] LABEL_BOTH  = 2'd3;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LABEL_RULE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [SCORE_W-1:0] none;
        logic [SCORE_W-1:0] last;
        logic [SCORE_W-1:0] first;
    } t_scores;

    typedef struct packed {
        t_word   word;
        t_scores scores;
    } t_entry;

    typedef struct packed {
        logic               label_rule;
        logic [SCORE_W-1:0] threshold;
    } t_cfg;

    function automatic logic [SCORE_W-1:0] sat_score(input logic [SCORE_W-1:0] v);
        return (v > SCORE_MAX) ? SCORE_MAX : v;
    endfunction

    function automatic logic [LABEL_W-1:0] classify(input t_scores s, input t_cfg cfg);
        logic [LABEL_W-1:0] lbl;
        if (!cfg.label_rule) begin
            if (s.first != '0 && s.last != '0) begin
                lbl = LABEL_BOTH;
            end else if (s.last != '0) begin
                lbl = LABEL_LAST;
            end else begin
                lbl = LABEL_FIRST;
            end
        end else begin
            if (s.none > s.last && s.none > s.first) begin
                lbl = LABEL_NONE;
            end else if (s.last > cfg.threshold) begin
                lbl = LABEL_LAST;
            end else begin
                lbl = LABEL_FIRST;
            end
        end
        return lbl;
    endfunction

endpackage

// File: rtl/sorted_dictionary_word_labeler.sv
// Top level of the sorted dictionary word labeler: configuration registers and table.
//
// An item is taken when start is high and busy is low; its result is registered and
// shown for exactly one cycle with o_done high, and cannot be held off.
// A load leaves busy low, so loads may be issued every cycle.
// A lookup runs a binary search over the loaded entries in the table memory; each
// probe first addresses the memory, then compares the registered entry, and busy
// stays high until the result appears.
// Table entries hold no reset value and need no clearing.
module sorted_dictionary_word_labeler
    import sdwl_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_req_type,
    input  logic [PART_W-1:0]     i_word_part0,
    input  logic [PART_W-1:0]     i_word_part1,
    input  logic [PART_W-1:0]     i_word_part2,
    input  logic [PART_W-1:0]     i_word_part3,
    input  logic [SCORE_W-1:0]    i_score_first,
    input  logic [SCORE_W-1:0]    i_score_last,
    input  logic [SCORE_W-1:0]    i_score_none,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [LABEL_W-1:0]    o_label,
    output logic                  o_found,
    output logic [LOC_W-1:0]      o_location
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic               r_label_rule;
    logic [SCORE_W-1:0] r_threshold;
    t_cfg               cfg;
    t_scores            scores;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    t_entry             rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_rule <= 1'b0;
            r_threshold  <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LABEL_RULE: r_label_rule <= i_cfg_data[0];
                REG_THRESHOLD:  r_threshold  <= i_cfg_data[SCORE_W-1:0];
                default:        r_label_rule <= r_label_rule;
            endcase
        end
    end

    assign cfg    = '{label_rule: r_label_rule, threshold: r_threshold};
    assign scores = '{none: i_score_none, last: i_score_last, first: i_score_first};

    sdwl_search #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req_type (i_req_type),
        .i_key      ({i_word_part0, i_word_part1, i_word_part2, i_word_part3}),
        .i_scores   (scores),
        .i_cfg      (cfg),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_label    (o_label),
        .o_found    (o_found),
        .o_location (o_location)
    );

    sdwl_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// File: rtl/sdwl_table.sv
// Dictionary table memory: one write port and one registered read port.
module sdwl_table
    import sdwl_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/sdwl_search.sv
// Load and binary search sequencer with result registers.
module sdwl_search
    import sdwl_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_req_type,
    input  t_word               i_key,
    input  t_scores             i_scores,
    input  t_cfg                i_cfg,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output t_entry              o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  t_entry              i_rd_data,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [LABEL_W-1:0]  o_label,
    output logic                o_found,
    output logic [LOC_W-1:0]    o_location
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [AW-1:0]       r_mid, n_mid;
    t_word               r_key, n_key;
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [LABEL_W-1:0]  r_label, n_label;
    logic                r_found, n_found;
    logic [LOC_W-1:0]    r_location, n_location;
    logic [CW:0]         mid_sum;
    logic                accept;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_key      = r_key;
        n_done     = 1'b0;
        n_status   = r_status;
        n_label    = r_label;
        n_found    = r_found;
        n_location = r_location;
        o_wr_en    = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = mid_sum[AW:1];
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        n_done     = 1'b1;
                        n_label    = LABEL_NONE;
                        n_found    = 1'b0;
                        n_location = '0;
                        if (r_count == FULL_COUNT) begin
                            n_status = STATUS_DROPPED;
                        end else begin
                            o_wr_en  = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_status = STATUS_LOADED;
                        end
                    end else begin
                        n_key   = i_key;
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hi) begin
                    o_rd_en = 1'b1;
                    n_mid   = mid_sum[AW:1];
                    n_state = ST_CMP;
                end else begin
                    n_done     = 1'b1;
                    n_status   = STATUS_LOOKUP;
                    n_label    = LABEL_NONE;
                    n_found    = 1'b0;
                    n_location = '0;
                    n_state    = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (r_key < i_rd_data.word) begin
                    n_hi    = CW'(r_mid);
                    n_state = ST_PROBE;
                end else if (r_key > i_rd_data.word) begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = ST_PROBE;
                end else begin
                    n_done     = 1'b1;
                    n_status   = STATUS_LOOKUP;
                    n_label    = classify(i_rd_data.scores, i_cfg);
                    n_found    = 1'b1;
                    n_location = LOC_W'(r_mid);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_key      <= n_key;
        r_status   <= n_status;
        r_label    <= n_label;
        r_found    <= n_found;
        r_location <= n_location;
    end

    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = '{word: i_key,
                         scores: '{none: sat_score(i_scores.none),
                                   last: sat_score(i_scores.last),
                                   first: sat_score(i_scores.first)}};

    assign o_busy     = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_label    = r_label;
    assign o_found    = r_found;
    assign o_location = r_location;

endmodule

// File: rtl/sdwl_chk.sv
// Port-level checker for the sorted dictionary word labeler, bound to the top level.
module sdwl_chk
    import sdwl_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                i_req_type,
    input logic                o_done,
    input logic [STATUS_W-1:0] o_status,
    input logic [LABEL_W-1:0]  o_label,
    input logic                o_found,
    input logic [LOC_W-1:0]    o_location
);

    // A load answers in the very next cycle with a load status.
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == REQ_LOAD)
        |=> (o_done && (o_status == STATUS_LOADED || o_status == STATUS_DROPPED)))
        else $error("load item not answered in the next cycle");

    // A lookup always occupies the block, with no result, in the cycle after it is taken.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == REQ_LOOKUP) |=> (busy && !o_done))
        else $error("lookup item did not occupy the block");

    // The end of a lookup is marked by its result.
    a_lookup_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_done && o_status == STATUS_LOOKUP))
        else $error("lookup ended without a result");

    // Load results and failed lookups carry no label, match or location.
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STATUS_LOOKUP || !o_found))
        |-> (!o_found && o_label == LABEL_NONE && o_location == '0))
        else $error("result fields set without a match");

endmodule

bind sorted_dictionary_word_labeler sdwl_chk u_chk (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted dictionary word labeler, with directed and random items.
module testbench
    import sdwl_pkg::*;
();

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LABEL_W-1:0]  label;
        logic                found;
        logic [LOC_W-1:0]    location;
    } t_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_req_type;
    logic [PART_W-1:0]     i_word_part0;
    logic [PART_W-1:0]     i_word_part1;
    logic [PART_W-1:0]     i_word_part2;
    logic [PART_W-1:0]     i_word_part3;
    logic [SCORE_W-1:0]    i_score_first;
    logic [SCORE_W-1:0]    i_score_last;
    logic [SCORE_W-1:0]    i_score_none;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [LABEL_W-1:0]    o_label;
    logic                  o_found;
    logic [LOC_W-1:0]      o_location;

    sorted_dictionary_word_labeler #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_word_part0 (i_word_part0),
        .i_word_part1 (i_word_part1),
        .i_word_part2 (i_word_part2),
        .i_word_part3 (i_word_part3),
        .i_score_first(i_score_first),
        .i_score_last (i_score_last),
        .i_score_none (i_score_none),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_label      (o_label),
        .o_found      (o_found),
        .o_location   (o_location)
    );

    t_word              dict_word [DEPTH];
    t_scores            dict_score[DEPTH];
    int                 dict_count;
    logic               rule_sel;
    logic [SCORE_W-1:0] last_thr;
    t_word              last_sorted;

    t_outcome pending[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX) begin
                    $display("Unrequested result: status %0d label %0d found %0d location %0d",
                             o_status, o_label, o_found, o_location);
                end
            end else begin
                want = pending.pop_front();
                if (o_status !== want.status || o_label !== want.label
                        || o_found !== want.found || o_location !== want.location) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("Mismatch: expected status %0d label %0d found %0d",
                                 want.status, want.label, want.found,
                                 " location %0d,", want.location,
                                 " actual status %0d label %0d found %0d",
                                 o_status, o_label, o_found,
                                 " location %0d", o_location);
                    end
                end
            end
        end
    end

    function automatic logic [SCORE_W-1:0] clip_score(input logic [SCORE_W-1:0] v);
        return (v > SCORE_MAX) ? SCORE_MAX : v;
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label(input t_scores s);
        if (rule_sel == 1'b0) begin
            if (s.first != 0 && s.last != 0) return LABEL_BOTH;
            if (s.last != 0) return LABEL_LAST;
            return LABEL_FIRST;
        end
        if (s.none > s.last && s.none > s.first) return LABEL_NONE;
        if (s.last > last_thr) return LABEL_LAST;
        return LABEL_FIRST;
    endfunction

    // Updates the local copy of the table and returns the result the item should give.
    function automatic t_outcome apply_item(input logic req, input t_word w, input t_scores s);
        t_outcome r;
        t_scores  c;
        int       lo;
        int       hi;
        int       mid;
        r = '0;
        if (req == REQ_LOAD) begin
            if (dict_count >= DEPTH) begin
                r.status = STATUS_DROPPED;
            end else begin
                c.first = clip_score(s.first);
                c.last  = clip_score(s.last);
                c.none  = clip_score(s.none);
                dict_word[dict_count]  = w;
                dict_score[dict_count] = c;
                dict_count++;
                r.status = STATUS_LOADED;
            end
        end else begin
            r.status = STATUS_LOOKUP;
            lo = 0;
            hi = dict_count;
            while (lo < hi && !r.found) begin
                mid = (lo + hi) / 2;
                if (w < dict_word[mid]) begin
                    hi = mid;
                end else if (w > dict_word[mid]) begin
                    lo = mid + 1;
                end else begin
                    r.found    = 1'b1;
                    r.location = mid[LOC_W-1:0];
                    r.label    = pick_label(dict_score[mid]);
                end
            end
        end
        return r;
    endfunction

    function automatic t_word text_word(input string txt);
        t_word w;
        w = '0;
        for (int i = 0; i < txt.len() && i < 32; i++) w[255-8*i -: 8] = txt[i];
        return w;
    endfunction

    function automatic t_word rand_word();
        t_word w;
        for (int i = 0; i < 8; i++) w[32*i +: 32] = $urandom;
        return w;
    endfunction

    function automatic t_word rand_text_word();
        t_word w;
        int    len;
        w   = '0;
        len = $urandom_range(1, 32);
        for (int i = 0; i < len; i++) w[255-8*i -: 8] = 8'($urandom_range(97, 122));
        return w;
    endfunction

    // Next word above the last sorted one, leaving room for the entries still to come.
    function automatic t_word next_sorted();
        t_word room;
        t_word step;
        t_word r;
        room = ~last_sorted;
        step = room / (DEPTH - dict_count + 1);
        if (step == 0) step = 1;
        r = rand_word() >> $urandom_range(0, 255);
        return last_sorted + 1 + (r % step);
    endfunction

    function automatic t_word lookup_key();
        t_word w;
        int    idx;
        if (dict_count == 0) return rand_word();
        idx = $urandom_range(0, dict_count - 1);
        case ($urandom_range(0, 9))
            0: w = dict_word[idx] ^ (t_word'(1) << $urandom_range(0, 255));
            1: w = dict_word[idx] + 1;
            2: w = dict_word[idx] - 1;
            3: w = rand_word();
            4: w = rand_text_word();
            default: w = dict_word[idx];
        endcase
        return w;
    endfunction

    function automatic logic [SCORE_W-1:0] rand_score();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 7'($urandom_range(100, 127));
            2: return 7'($urandom_range(1, 3));
            3: return 7'($urandom_range(78, 82));
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic send_item(input logic req, input t_word w, input t_scores s);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_req_type    <= req;
        i_word_part0  <= w[255:192];
        i_word_part1  <= w[191:128];
        i_word_part2  <= w[127:64];
        i_word_part3  <= w[63:0];
        i_score_first <= s.first;
        i_score_last  <= s.last;
        i_score_none  <= s.none;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending.push_back(apply_item(req, w, s));
        burst_left--;
    endtask

    task automatic load_entry(input t_word w, input logic [SCORE_W-1:0] f,
                              input logic [SCORE_W-1:0] l, input logic [SCORE_W-1:0] n);
        t_scores s;
        s.first = f;
        s.last  = l;
        s.none  = n;
        send_item(REQ_LOAD, w, s);
    endtask

    task automatic look_up(input t_word w);
        t_scores s;
        s.first = rand_score();
        s.last  = rand_score();
        s.none  = rand_score();
        send_item(REQ_LOOKUP, w, s);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_LABEL_RULE) begin
            rule_sel = data[0];
        end else begin
            last_thr = data;
        end
    endtask

    task automatic set_config(input logic rule, input logic [SCORE_W-1:0] thr);
        logic [CFG_DATA_W-2:0] junk;
        junk = (CFG_DATA_W-1)'($urandom);
        wait_idle();
        write_reg(REG_LABEL_RULE, {junk, rule});
        write_reg(REG_THRESHOLD, thr);
    endtask

    task automatic random_config();
        logic [SCORE_W-1:0] thr;
        case ($urandom_range(0, 4))
            0: thr = '0;
            1: thr = THRESHOLD_RESET;
            2: thr = SCORE_MAX;
            3: thr = '1;
            default: thr = SCORE_W'($urandom_range(0, 127));
        endcase
        set_config(1'($urandom_range(0, 1)), thr);
    endtask

    task automatic test_empty_table();
        look_up(text_word("alba"));
        look_up('0);
    endtask

    // Five sorted entries; two share the prefix alba and differ only after the zero padding.
    task automatic test_directed_entries();
        load_entry('0, 7'd0, 7'd0, 7'd0);
        load_entry(text_word("alba"), 7'd127, 7'd0, 7'd50);
        load_entry(text_word("alba") | t_word'(1), 7'd0, 7'd101, 7'd0);
        load_entry(text_word("bob"), 7'd60, 7'd81, 7'd127);
        load_entry(text_word("carmen"), 7'd1, 7'd1, 7'd1);
        last_sorted = text_word("carmen");
        look_up('0);
        look_up(text_word("alba"));
        look_up(text_word("alba") | t_word'(1));
        look_up(text_word("bob"));
        look_up(text_word("carmen"));
        look_up(text_word("alba") | t_word'(256));
        look_up('1);
    endtask

    task automatic test_refined_rule();
        wait_idle();
        write_reg(REG_LABEL_RULE, 7'b1010101);
        look_up(text_word("alba") | t_word'(1));
        look_up(text_word("bob"));
        look_up(text_word("alba"));
        set_config(1'b1, 7'd0);
        look_up(text_word("carmen"));
        look_up('0);
        set_config(1'b1, 7'd127);
        look_up(text_word("alba") | t_word'(1));
        look_up(text_word("carmen"));
    endtask

    // Mostly sorted loads mixed with lookups until the table is full.
    task automatic test_random_fill();
        int till_cfg;
        int pick;
        till_cfg = 0;
        while (dict_count < DEPTH) begin
            if (till_cfg <= 0) begin
                random_config();
                till_cfg = $urandom_range(80, 200);
            end
            till_cfg--;
            if ($urandom_range(0, 99) < 35) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    load_entry(rand_word(), rand_score(), rand_score(), rand_score());
                end else if (pick < 3) begin
                    load_entry(last_sorted, rand_score(), rand_score(), rand_score());
                end else begin
                    last_sorted = next_sorted();
                    load_entry(last_sorted, rand_score(), rand_score(), rand_score());
                end
            end else begin
                look_up(lookup_key());
            end
        end
    endtask

    task automatic test_table_full();
        int till_cfg;
        load_entry('1, 7'd127, 7'd127, 7'd127);
        till_cfg = 0;
        repeat (1250) begin
            if (till_cfg <= 0) begin
                random_config();
                till_cfg = $urandom_range(80, 200);
            end
            till_cfg--;
            if ($urandom_range(0, 9) == 0) begin
                load_entry(($urandom_range(0, 1) == 0) ? rand_word() : rand_text_word(),
                           rand_score(), rand_score(), rand_score());
            end else begin
                look_up(lookup_key());
            end
        end
    endtask

    initial begin
        start         <= 1'b0;
        i_rst_n       <= 1'b0;
        i_req_type    <= REQ_LOAD;
        i_word_part0  <= '0;
        i_word_part1  <= '0;
        i_word_part2  <= '0;
        i_word_part3  <= '0;
        i_score_first <= '0;
        i_score_last  <= '0;
        i_score_none  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_LABEL_RULE;
        i_cfg_data    <= '0;
        dict_count  = 0;
        rule_sel    = 1'b0;
        last_thr    = THRESHOLD_RESET;
        last_sorted = '0;
        burst_left  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_directed_entries();
        test_refined_rule();
        test_random_fill();
        test_table_full();

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sdwl_pkg.sv
rtl/sdwl_table.sv
rtl/sdwl_search.sv
rtl/sorted_dictionary_word_labeler.sv
rtl/sdwl_chk.sv
bench/testbench.sv
